// File: rtl/core/icmpv6_error_reply_parser_assert.svh
// Assertion macros used by the checker file.
`ifndef ICMPV6_ERROR_REPLY_PARSER_ASSERT_SVH
`define ICMPV6_ERROR_REPLY_PARSER_ASSERT_SVH

// Implication checked every clock outside reset.
`define ICERP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icerp assertion failed");

// Next-cycle implication checked every clock outside reset.
`define ICERP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icerp assertion failed");

// Next-cycle implication checked during reset too.
`define ICERP_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("icerp assertion failed");

`endif

// File: rtl/core/icerp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package icerp_pkg;
    localparam int LEN_W = 17;
    localparam int EXT_PAD_BYTES = 128;
    localparam int EXT_START = 8 + EXT_PAD_BYTES;
    localparam int NUM_KINDS = 14;

    // record kinds
    localparam logic [3:0] K_VERDICT   = 4'd0;
    localparam logic [3:0] K_TYPE_CODE = 4'd1;
    localparam logic [3:0] K_ECHO      = 4'd2;
    localparam logic [3:0] K_PROTO     = 4'd3;
    localparam logic [3:0] K_HOPLIMIT  = 4'd4;
    localparam logic [3:0] K_INNER_SZ  = 4'd5;
    localparam logic [3:0] K_FLOW      = 4'd6;
    localparam logic [3:0] K_DST_HI    = 4'd7;
    localparam logic [3:0] K_DST_LO    = 4'd8;
    localparam logic [3:0] K_TRANSPORT = 4'd9;
    localparam logic [3:0] K_FRAG      = 4'd10;
    localparam logic [3:0] K_MTU       = 4'd11;
    localparam logic [3:0] K_SIZE      = 4'd12;
    localparam logic [3:0] K_EXTLEN    = 4'd13;

    // verdicts
    localparam logic [2:0] V_SHORT     = 3'd0;
    localparam logic [2:0] V_UNWANTED  = 3'd1;
    localparam logic [2:0] V_BAD_NEXT  = 3'd2;
    localparam logic [2:0] V_TRUNCATED = 3'd3;
    localparam logic [2:0] V_ECHO      = 3'd4;
    localparam logic [2:0] V_ERROR     = 3'd5;

    typedef struct packed {
        logic [NUM_KINDS-1:0] mask;
        logic [2:0]           verdict;
        logic [63:0]          icmp_head;
        logic [7:0]           next_header;
        logic [7:0]           hop_limit;
        logic [15:0]          payload_len;
        logic [31:0]          flow_word;
        logic [63:0]          dst_hi;
        logic [63:0]          dst_lo;
        logic [63:0]          transport;
        logic [44:0]          frag;
        logic [15:0]          mtu;
        logic [LEN_W-1:0]     len;
        logic [LEN_W-1:0]     ext_len;
    } t_summary;
endpackage
`default_nettype wire

// File: rtl/core/icerp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface icerp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;
    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/core/icerp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface icerp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  record_kind;
    logic [63:0] record_value;
    logic        last_record;
    modport source (output valid, output record_kind, output record_value,
                    output last_record, input ready);
    modport sink (input valid, input record_kind, input record_value,
                  input last_record, output ready);
endinterface
`default_nettype wire

// File: rtl/core/icerp_capture.sv
`timescale 1ns / 1ps
`default_nettype none
module icerp_capture #(
    parameter int MAX_PACKET_BYTES = 65536
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_take,
    input  wire [7:0]           i_byte,
    input  wire                 i_last,
    output logic                o_done,
    output icerp_pkg::t_summary o_sum
);
    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int PW = (CW < 9) ? 9 : CW;
    localparam int HW = PW + 1;

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    logic [PW-1:0] r_count, n_count;
    logic [HW-1:0] r_hs, n_hs;
    logic [7:0]    r_nh, n_nh;
    logic [63:0]   r_head, n_head;
    logic [31:0]   r_flow, n_flow;
    logic [15:0]   r_plen, n_plen;
    logic [7:0]    r_hop, n_hop;
    logic [63:0]   r_dst0, n_dst0;
    logic [63:0]   r_dst1, n_dst1;
    logic [63:0]   r_th, n_th;
    logic [44:0]   r_frag, n_frag;
    logic [2:0]    r_verdict, n_verdict;
    logic [31:0]   r_lead, n_lead;
    logic [15:0]   r_esum, n_esum;
    logic [7:0]    r_odd, n_odd;
    logic          r_done;
    icerp_pkg::t_summary r_sum, n_sum;

    logic [PW-1:0] rel;
    logic [12:0]   off;
    logic [7:0]    typ, cod;
    logic [16:0]   mtu_s;
    logic [15:0]   mtu_f;
    logic [15:0]   fin_sum;
    logic [PW-1:0] elen;

    always_comb begin
        n_count = r_count; n_hs = r_hs; n_nh = r_nh; n_head = r_head;
        n_flow = r_flow; n_plen = r_plen; n_hop = r_hop; n_dst0 = r_dst0;
        n_dst1 = r_dst1; n_th = r_th; n_frag = r_frag; n_verdict = r_verdict;
        n_lead = r_lead; n_esum = r_esum; n_odd = r_odd;
        rel = r_count - PW'(icerp_pkg::EXT_START);
        off = 13'd0;
        if (i_take && (r_count < PW'(MAX_PACKET_BYTES))) begin
            n_count = r_count + PW'(1);
            if (r_count < PW'(8)) begin
                n_head = {r_head[55:0], i_byte};
            end else if (r_count < PW'(12)) begin
                n_flow = {r_flow[23:0], i_byte};
            end else if (r_count < PW'(14)) begin
                n_plen = {r_plen[7:0], i_byte};
            end else if (r_count == PW'(14)) begin
                n_nh = i_byte;
            end else if (r_count == PW'(15)) begin
                n_hop = i_byte;
            end else if (r_count >= PW'(32) && r_count < PW'(40)) begin
                n_dst0 = {r_dst0[55:0], i_byte};
            end else if (r_count >= PW'(40) && r_count < PW'(48)) begin
                n_dst1 = {r_dst1[55:0], i_byte};
            end
            if (r_verdict == icerp_pkg::V_TRUNCATED && {1'b0, r_count} >= r_hs) begin
                n_th = {r_th[55:0], i_byte};
                if ({1'b0, r_count} == r_hs + HW'(7)) begin
                    if (r_nh == 8'd17 || r_nh == 8'd6 || r_nh == 8'd58) begin
                        n_verdict = icerp_pkg::V_ERROR;
                    end else if (r_nh == 8'd44) begin
                        off = n_th[47:35];
                        n_nh = n_th[63:56];
                        n_frag = {off, n_th[31:0]};
                        n_hs = r_hs + HW'(8);
                        if (off != 13'd0) begin
                            n_verdict = icerp_pkg::V_ERROR;
                        end
                    end else begin
                        n_verdict = icerp_pkg::V_BAD_NEXT;
                    end
                end
            end
            if (r_count >= PW'(icerp_pkg::EXT_START)) begin
                if (rel < PW'(4)) begin
                    n_lead = {r_lead[23:0], i_byte};
                end
                if (!rel[0]) begin
                    n_odd = i_byte;
                end else begin
                    n_esum = fold_add(r_esum, {r_odd, i_byte});
                end
            end
        end

        // build the packet summary from the updated state
        typ = n_head[63:56];
        cod = n_head[55:48];
        mtu_s = {1'b0, n_head[31:16]} + {1'b0, n_head[15:0]};
        mtu_f = mtu_s[15:0] + {15'd0, mtu_s[16]};
        elen = n_count - PW'(icerp_pkg::EXT_START);
        fin_sum = elen[0] ? fold_add(n_esum, {n_odd, 8'h00}) : n_esum;

        n_sum.icmp_head = n_head;
        n_sum.next_header = n_nh;
        n_sum.hop_limit = n_hop;
        n_sum.payload_len = n_plen;
        n_sum.flow_word = n_flow;
        n_sum.dst_hi = n_dst0;
        n_sum.dst_lo = n_dst1;
        n_sum.transport = n_th;
        n_sum.frag = n_frag;
        n_sum.mtu = (mtu_f == 16'hffff) ? 16'd0 : mtu_f;
        n_sum.len = icerp_pkg::LEN_W'(n_count);
        n_sum.ext_len = icerp_pkg::LEN_W'(elen);
        if (n_count < PW'(8)) begin
            n_sum.verdict = icerp_pkg::V_SHORT;
        end else if (!((typ == 8'd3 && cod == 8'd0) || typ == 8'd1 || typ == 8'd2
                       || typ == 8'd129)) begin
            n_sum.verdict = icerp_pkg::V_UNWANTED;
        end else if (typ == 8'd129) begin
            n_sum.verdict = icerp_pkg::V_ECHO;
        end else begin
            n_sum.verdict = n_verdict;
        end
        n_sum.mask = '0;
        n_sum.mask[icerp_pkg::K_VERDICT] = 1'b1;
        if (n_sum.verdict == icerp_pkg::V_ECHO) begin
            n_sum.mask[icerp_pkg::K_TYPE_CODE] = 1'b1;
            n_sum.mask[icerp_pkg::K_ECHO] = 1'b1;
            n_sum.mask[icerp_pkg::K_SIZE] = 1'b1;
        end else if (n_sum.verdict == icerp_pkg::V_ERROR) begin
            n_sum.mask[icerp_pkg::K_TYPE_CODE] = 1'b1;
            n_sum.mask[icerp_pkg::K_FRAG:icerp_pkg::K_PROTO] = '1;
            n_sum.mask[icerp_pkg::K_MTU] = (typ == 8'd2);
            n_sum.mask[icerp_pkg::K_SIZE] = 1'b1;
            n_sum.mask[icerp_pkg::K_EXTLEN] =
                (n_count > PW'(icerp_pkg::EXT_START + 4)) && (n_lead[31:28] == 4'h2)
                && (n_lead[15:0] == 16'd0 || fin_sum == 16'hffff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_count <= '0; r_hs <= HW'(48); r_nh <= '0; r_head <= '0;
            r_flow <= '0; r_plen <= '0; r_hop <= '0; r_dst0 <= '0; r_dst1 <= '0;
            r_th <= '0; r_frag <= '0; r_verdict <= icerp_pkg::V_TRUNCATED;
            r_lead <= '0; r_esum <= '0; r_odd <= '0;
        end else begin
            r_count <= n_count; r_hs <= n_hs; r_nh <= n_nh; r_head <= n_head;
            r_flow <= n_flow; r_plen <= n_plen; r_hop <= n_hop; r_dst0 <= n_dst0;
            r_dst1 <= n_dst1; r_th <= n_th; r_frag <= n_frag; r_verdict <= n_verdict;
            r_lead <= n_lead; r_esum <= n_esum; r_odd <= n_odd;
        end
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_take && i_last;
        end
        if (i_take && i_last) begin
            r_sum <= n_sum;
        end
    end

    assign o_done = r_done;
    assign o_sum = r_sum;
endmodule
`default_nettype wire

// File: rtl/core/icerp_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module icerp_emit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  icerp_pkg::t_summary i_sum,
    output logic                o_busy,
    icerp_out_if.source         o_out
);
    icerp_pkg::t_summary r_sum;
    logic [icerp_pkg::NUM_KINDS-1:0] r_mask, pick;
    logic [3:0]  kind;
    logic [63:0] value;
    logic        r_valid;
    logic [3:0]  r_kind;
    logic [63:0] r_value;
    logic        r_last;
    logic        advance;

    always_comb begin
        kind = '0;
        for (int i = icerp_pkg::NUM_KINDS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                kind = 4'(i);
            end
        end
        pick = '0;
        pick[kind] = 1'b1;
        case (kind)
            icerp_pkg::K_VERDICT:   value = {61'd0, r_sum.verdict};
            icerp_pkg::K_TYPE_CODE: value = {48'd0, r_sum.icmp_head[63:48]};
            icerp_pkg::K_ECHO:      value = {32'd0, r_sum.icmp_head[31:0]};
            icerp_pkg::K_PROTO:     value = {56'd0, r_sum.next_header};
            icerp_pkg::K_HOPLIMIT:  value = {56'd0, r_sum.hop_limit};
            icerp_pkg::K_INNER_SZ:  value = {48'd0, r_sum.payload_len} + 64'd40;
            icerp_pkg::K_FLOW:      value = {36'd0, r_sum.flow_word[27:0]};
            icerp_pkg::K_DST_HI:    value = r_sum.dst_hi;
            icerp_pkg::K_DST_LO:    value = r_sum.dst_lo;
            icerp_pkg::K_TRANSPORT: value = (r_sum.frag[44:32] != 13'd0) ? 64'd0
                                                                          : r_sum.transport;
            icerp_pkg::K_FRAG:      value = {19'd0, r_sum.frag};
            icerp_pkg::K_MTU:       value = {48'd0, r_sum.mtu};
            icerp_pkg::K_SIZE:      value = 64'(r_sum.len) + 64'd40;
            icerp_pkg::K_EXTLEN:    value = 64'(r_sum.ext_len);
            default:                value = 64'd0;
        endcase
    end

    assign advance = (r_mask != '0) && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_mask <= i_sum.mask;
            end else if (advance) begin
                r_mask <= r_mask & ~pick;
            end
            if (advance) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
        if (i_load) begin
            r_sum <= i_sum;
        end
        if (advance) begin
            r_kind  <= kind;
            r_value <= value;
            r_last  <= ((r_mask & ~pick) == '0);
        end
    end

    assign o_busy = (r_mask != '0);
    assign o_out.valid = r_valid;
    assign o_out.record_kind = r_kind;
    assign o_out.record_value = r_value;
    assign o_out.last_record = r_last;
endmodule
`default_nettype wire

// File: rtl/core/icmpv6_error_reply_parser.sv
// ICMPv6 error and echo-reply parser. Bytes of one ICMPv6 message enter one
// per cycle from the type byte on, with last_byte set on the final byte. Each
// byte updates the header captures and the fragment-header walk in the same
// cycle, so the input takes one transaction per clock while ready is high. The
// final byte freezes a packet summary; the record sequencer then sends its
// records (1 to 13, in ascending kind order, last_record on the final one)
// one per cycle through an output register while the output is ready. Ready
// drops only for a final byte that arrives while the previous packet's summary
// or records are still queued: the summary is registered in the capture block,
// then loaded into the record sequencer, which drains one record per cycle
// while the output is ready.
`timescale 1ns / 1ps
`default_nettype none
module icmpv6_error_reply_parser #(
    parameter int MAX_PACKET_BYTES = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    icerp_in_if.sink    i_in,
    icerp_out_if.source o_out
);
    logic                take;
    logic                done;
    logic                busy;
    icerp_pkg::t_summary summary;

    // hold off a final byte until the summary slot is free
    assign i_in.ready = !(i_in.last_byte && (busy || done));
    assign take = i_in.valid && i_in.ready;

    icerp_capture #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_capture (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_byte (i_in.packet_byte),
        .i_last (i_in.last_byte),
        .o_done (done),
        .o_sum  (summary)
    );

    // advance records out of the frozen summary
    icerp_emit u_emit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (done),
        .i_sum  (summary),
        .o_busy (busy),
        .o_out  (o_out)
    );
endmodule
`default_nettype wire

// File: rtl/core/icerp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "icmpv6_error_reply_parser_assert.svh"
module icerp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [3:0]  i_out_kind,
    input wire        i_out_last
);
    `ICERP_ASSERT_NEXT(a_hold_stall, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_last))
    `ICERP_ASSERT_IMPL(a_kind_range, i_out_valid, i_out_kind <= 4'd13)
    `ICERP_ASSERT_RST(a_reset_idle, !i_rst_n, !i_out_valid)
    `ICERP_ASSERT_NEXT(a_verdict_first, i_out_valid && i_out_ready && i_out_last, !i_out_valid || i_out_kind == 4'd0)
endmodule

bind icmpv6_error_reply_parser icerp_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_kind (o_out.record_kind),
    .i_out_last (o_out.last_record)
);
`default_nettype wire
